FILE: hw/rtl/g24d_pkg.sv
package g24d_pkg;

    localparam int CW_W   = 24;
    localparam int CYC_W  = 23;
    localparam int SYN_W  = 11;
    localparam int DATA_W = 12;
    localparam int CNT_W  = 4;
    localparam int ROT_W  = 5;
    localparam int PASS_W = 5;

    localparam logic [CYC_W-1:0]  GEN_POLY   = 23'hAE3;
    localparam logic [CYC_W-1:0]  CHECK_INV  = 23'h7FF000;
    localparam logic [ROT_W-1:0]  LAST_ROT   = 5'd22;
    localparam logic [PASS_W-1:0] LAST_PASS  = 5'd23;
    localparam logic [CNT_W-1:0]  LIMIT_BASE = 4'd3;
    localparam logic [CNT_W-1:0]  LIMIT_FLIP = 4'd2;
    localparam logic [CNT_W-1:0]  ODD_COUNT  = 4'd1;

    typedef struct packed {
        logic [SYN_W-1:0] syn;
        logic [CNT_W-1:0] weight;
    } syn_res_t;

    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] data;
        logic [CNT_W-1:0]  count;
    } dec_res_t;

    // Syndrome of a word with only bit j set; the syndrome is linear in the word.
    function automatic logic [SYN_W-1:0] syn_col(int j);
        logic [CYC_W-1:0] v;
        v = CYC_W'(1) << j;
        for (int k = 0; k < 12; k++)
        begin
            if (v[0])
            begin
                v = v ^ GEN_POLY;
            end
            v = v >> 1;
        end
        return v[SYN_W-1:0];
    endfunction

    function automatic logic [CYC_W-1:0][SYN_W-1:0] gen_cols();
        logic [CYC_W-1:0][SYN_W-1:0] cols;
        for (int j = 0; j < CYC_W; j++)
        begin
            cols[j] = syn_col(j);
        end
        return cols;
    endfunction

    localparam logic [CYC_W-1:0][SYN_W-1:0] SYN_COLS = gen_cols();

endpackage

FILE: hw/rtl/golay_24_12_decoder.sv
// Extended Golay (24,12) decoder by error trapping.
// Input channel: codeword (24 bits) with in_valid/in_ready. Bit 23 is the
// overall parity, bits 22..12 the check bits and bits 11..0 the data.
// Output channel: data_out (12 bits) and error_count (4 bits) with
// out_valid/out_ready; one output word for every input word, in order.
// A single syndrome and weight unit is reused for every rotation of the
// 23-bit cyclic part, one rotation per cycle, so the latency depends on
// where the error pattern is trapped. A clean word is done at its first
// syndrome check, and the next word can be accepted once its result has
// moved to the output register. The longest case traps late in the last
// of 24 trial passes of 23 rotations, then rotates back.
// The block takes one word at a time: in_ready is high only while the
// sequencer is idle. A finished word moves to the output register and the
// next word can be accepted while it waits; if the receiver stalls with a
// word still held, the next result waits in the sequencer.
// Reset clears the sequencer and the output valid flag; no word is pending.
module golay_24_12_decoder (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [g24d_pkg::CW_W-1:0]          codeword,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [g24d_pkg::DATA_W-1:0]        data_out,
    output logic [g24d_pkg::CNT_W-1:0]         error_count
);
    import g24d_pkg::*;

    logic              idle;
    logic              start;
    logic              take;
    logic [CYC_W-1:0]  word;
    syn_res_t          syn_res;
    dec_res_t          res;

    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] data_reg;
    logic [CNT_W-1:0]  count_reg;

    assign in_ready = idle;
    assign start    = in_valid && idle;
    assign take     = res.valid && (!out_valid_reg || out_ready);

    g24d_syn_unit u_syn (
        .word (word),
        .res  (syn_res)
    );

    g24d_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .codeword (codeword),
        .idle     (idle),
        .word     (word),
        .syn_res  (syn_res),
        .res      (res),
        .take     (take)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg  <= res.data;
            count_reg <= res.count;
        end
    end

    assign out_valid   = out_valid_reg;
    assign data_out    = data_reg;
    assign error_count = count_reg;

endmodule

FILE: hw/rtl/g24d_syn_unit.sv
module g24d_syn_unit (
    input  logic [g24d_pkg::CYC_W-1:0] word,
    output g24d_pkg::syn_res_t         res
);
    import g24d_pkg::*;

    logic [SYN_W-1:0] syn;
    logic [CNT_W-1:0] weight;

    // Each syndrome bit is the parity of the word masked by one matrix row.
    always_comb
    begin
        syn = '0;
        for (int j = 0; j < CYC_W; j++)
        begin
            if (word[j])
            begin
                syn = syn ^ SYN_COLS[j];
            end
        end
    end

    always_comb
    begin
        weight = '0;
        for (int b = 0; b < SYN_W; b++)
        begin
            weight = weight + CNT_W'(syn[b]);
        end
    end

    assign res.syn    = syn;
    assign res.weight = weight;

endmodule

FILE: hw/rtl/g24d_ctrl.sv
module g24d_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [g24d_pkg::CW_W-1:0]   codeword,
    output logic                        idle,
    output logic [g24d_pkg::CYC_W-1:0]  word,
    input  g24d_pkg::syn_res_t          syn_res,
    output g24d_pkg::dec_res_t          res,
    input  logic                        take
);
    import g24d_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UNROT,
        ST_FIN
    } state_t;

    state_t              state_reg, state_next;
    logic [CYC_W-1:0]    saved_reg, saved_next;
    logic [CYC_W-1:0]    w_reg, w_next;
    logic                pbit_reg, pbit_next;
    logic [PASS_W-1:0]   pass_reg, pass_next;
    logic [ROT_W-1:0]    rot_reg, rot_next;
    logic [CNT_W-1:0]    last_reg, last_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    limit;
    logic                odd;

    assign limit = (pass_reg == '0) ? LIMIT_BASE : LIMIT_FLIP;
    assign odd   = ^{pbit_reg, w_reg};

    always_comb
    begin
        state_next = state_reg;
        saved_next = saved_reg;
        w_next     = w_reg;
        pbit_next  = pbit_reg;
        pass_next  = pass_reg;
        rot_next   = rot_reg;
        last_next  = last_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    saved_next = codeword[CYC_W-1:0] ^ CHECK_INV;
                    w_next     = codeword[CYC_W-1:0] ^ CHECK_INV;
                    pbit_next  = codeword[CW_W-1];
                    pass_next  = '0;
                    rot_next   = '0;
                    last_next  = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (rot_reg == '0 && syn_res.syn == '0)
                begin
                    // A zero syndrome at the start of a pass keeps the earlier weight.
                    cnt_next   = last_reg;
                    state_next = ST_FIN;
                end
                else if (syn_res.weight <= limit)
                begin
                    w_next     = w_reg ^ {syn_res.syn, {(CYC_W-SYN_W){1'b0}}};
                    cnt_next   = syn_res.weight;
                    state_next = (rot_reg == '0) ? ST_FIN : ST_UNROT;
                end
                else
                begin
                    last_next = syn_res.weight;
                    if (rot_reg != LAST_ROT)
                    begin
                        w_next   = {w_reg[CYC_W-2:0], w_reg[CYC_W-1]};
                        rot_next = rot_reg + ROT_W'(1);
                    end
                    else if (pass_reg == LAST_PASS)
                    begin
                        // Nothing matched: the word goes out as received.
                        w_next     = saved_reg;
                        cnt_next   = syn_res.weight;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        // The next pass flips bit pass_reg of the received word.
                        w_next    = saved_reg ^ (CYC_W'(1) << pass_reg);
                        pass_next = pass_reg + PASS_W'(1);
                        rot_next  = '0;
                    end
                end
            end
            ST_UNROT:
            begin
                w_next   = {w_reg[0], w_reg[CYC_W-1:1]};
                rot_next = rot_reg - ROT_W'(1);
                if (rot_reg == ROT_W'(1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        saved_reg <= saved_next;
        w_reg     <= w_next;
        pbit_reg  <= pbit_next;
        pass_reg  <= pass_next;
        rot_reg   <= rot_next;
        last_reg  <= last_next;
        cnt_reg   <= cnt_next;
    end

    assign idle      = (state_reg == ST_IDLE);
    assign word      = w_reg;
    assign res.valid = (state_reg == ST_FIN);
    assign res.data  = w_reg[DATA_W-1:0];
    assign res.count = odd ? ODD_COUNT : cnt_reg;

endmodule
